>>> src/grid_point_plane_projector_macros.svh
// Assertion macros used by the checker file.
`ifndef GRID_POINT_PLANE_PROJECTOR_MACROS_SVH
`define GRID_POINT_PLANE_PROJECTOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GPPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GPPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/gppp_pkg.sv
package gppp_pkg;

    localparam int unsigned MAX_GRID_DIM_DEF = 1024;

    localparam int COL_W      = 10;
    localparam int HGT_W      = 16;
    localparam int COMP_W     = 16;
    localparam int VEC_W      = 3 * COMP_W;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_W      = 32;

    localparam logic [WORD_W-1:0]     INV_N2_RST     = 32'h0001_0000;
    localparam logic [CFG_DATA_W-1:0] INV_SCALES_RST = 64'h0001_0001_0001_0000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL     = 8'd0,
        REG_ORIGIN     = 8'd1,
        REG_P_AXIS     = 8'd2,
        REG_Q_AXIS     = 8'd3,
        REG_OFFSET     = 8'd4,
        REG_INV_N2     = 8'd5,
        REG_INV_SCALES = 8'd6,
        REG_CENTER     = 8'd7
    } t_reg_idx;

    typedef struct packed {
        logic [VEC_W-1:0]      normal;
        logic [VEC_W-1:0]      origin;
        logic [VEC_W-1:0]      p_axis;
        logic [VEC_W-1:0]      q_axis;
        logic [WORD_W-1:0]     offset;
        logic [WORD_W-1:0]     inv_n2;
        logic [CFG_DATA_W-1:0] inv_scales;
        logic [WORD_W-1:0]     center;
    } t_cfg;

    function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                      input int k);
        return $signed(v[COMP_W*k +: COMP_W]);
    endfunction

endpackage

>>> src/grid_point_plane_projector.sv
// Channel   Handshake                  Payload
// -------   -------------------------  -----------------------------------
// point in  i_valid / o_ready          i_column, i_row, i_height
// result    o_valid / i_ready          o_screen_x, o_screen_y, o_saturated
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One point enters per cycle while the result channel is not stalled.
// The pipeline holds four 4-stage split multipliers in series plus six glue stages.
// Reset clears the valid bits and loads the register defaults; config is always ready.
// A stalled result freezes the whole pipeline, so o_ready follows !o_valid || i_ready.
module grid_point_plane_projector #(
    parameter int MAX_GRID_DIM = gppp_pkg::MAX_GRID_DIM_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [gppp_pkg::COL_W-1:0]            i_column,
    input  logic [gppp_pkg::COL_W-1:0]            i_row,
    input  logic signed [gppp_pkg::HGT_W-1:0]     i_height,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [gppp_pkg::OUT_W-1:0]     o_screen_x,
    output logic signed [gppp_pkg::OUT_W-1:0]     o_screen_y,
    output logic                                  o_saturated,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gppp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gppp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int COL_W  = gppp_pkg::COL_W;
    localparam int COMP_W = gppp_pkg::COMP_W;
    localparam int OUT_W  = gppp_pkg::OUT_W;
    localparam int WORD_W = gppp_pkg::WORD_W;
    localparam int P_W    = 17;
    localparam int PN_W   = P_W + COMP_W;
    localparam int DOT_W  = PN_W + 2;
    localparam int DIFF_W = 39;
    localparam int INV_W  = WORD_W + 1;
    localparam int H_RW   = DIFF_W + INV_W - 16 + 1;
    localparam int H_W    = 55;
    localparam int T_RW   = H_W + COMP_W - 12 + 1;
    localparam int D_W    = 58;
    localparam int S_W    = D_W + COMP_W - 12 + 1;
    localparam int F_RW   = S_W + INV_W - 16 + 1;
    localparam int LAT    = 22;
    localparam int PD_N   = 11;

    gppp_pkg::t_cfg w_cfg;

    logic                    w_en;
    logic [LAT-1:0]          r_vld;
    logic [COL_W-1:0]        w_col;
    logic [COL_W-1:0]        w_row;
    logic signed [P_W-1:0]   w_p [3];
    logic signed [P_W-1:0]   r_pd [PD_N][3];
    logic signed [PN_W-1:0]  r_pn [3];
    logic signed [DOT_W-1:0] w_dot;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [H_RW-1:0]  w_hfull;
    logic signed [H_W-1:0]   w_h;
    logic signed [T_RW-1:0]  w_t [3];
    logic signed [D_W-1:0]   w_d [3];
    logic signed [D_W-1:0]   r_d [3];
    logic signed [S_W-1:0]   w_sp [3];
    logic signed [S_W-1:0]   w_sq [3];
    logic signed [S_W-1:0]   r_sp;
    logic signed [S_W-1:0]   r_sq;
    logic signed [F_RW-1:0]  w_fx;
    logic signed [F_RW-1:0]  w_fy;
    logic                    w_x_hi;
    logic                    w_x_lo;
    logic                    w_y_hi;
    logic                    w_y_lo;
    logic signed [OUT_W-1:0] r_x;
    logic signed [OUT_W-1:0] r_y;
    logic                    r_sat;

    gppp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_en        = !r_vld[LAT-1] || i_ready;
    assign o_ready     = w_en;
    assign o_valid     = r_vld[LAT-1];
    assign o_screen_x  = r_x;
    assign o_screen_y  = r_y;
    assign o_saturated = r_sat;

    assign w_col = (32'(i_column) >= 32'(MAX_GRID_DIM)) ? COL_W'(MAX_GRID_DIM - 1) : i_column;
    assign w_row = (32'(i_row) >= 32'(MAX_GRID_DIM)) ? COL_W'(MAX_GRID_DIM - 1) : i_row;

    assign w_p[0] = $signed({{(P_W-COL_W){1'b0}}, w_col})
                  - $signed({1'b0, w_cfg.center[15:0]});
    assign w_p[1] = $signed({{(P_W-COL_W){1'b0}}, w_row})
                  - $signed({1'b0, w_cfg.center[31:16]});
    assign w_p[2] = P_W'(i_height);

    assign w_dot  = DOT_W'(r_pn[0]) + DOT_W'(r_pn[1]) + DOT_W'(r_pn[2]);
    assign w_diff = DIFF_W'($signed(w_cfg.offset)) - (DIFF_W'(w_dot) <<< 4);
    assign w_h    = H_W'(w_hfull);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd[0] <= w_p;
            for (int i = 1; i < PD_N; i++) begin
                r_pd[i] <= r_pd[i-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_pn[k] <= PN_W'(r_pd[0][k]) * PN_W'(gppp_pkg::comp(w_cfg.normal, k));
                r_d[k]  <= w_d[k];
            end
            r_diff <= w_diff;
            r_sp   <= w_sp[0] + w_sp[1] + w_sp[2];
            r_sq   <= w_sq[0] + w_sq[1] + w_sq[2];
            r_sat  <= w_x_hi || w_x_lo || w_y_hi || w_y_lo;
            if (w_x_hi) begin
                r_x <= gppp_pkg::OUT_MAX;
            end else if (w_x_lo) begin
                r_x <= gppp_pkg::OUT_MIN;
            end else begin
                r_x <= OUT_W'(w_fx);
            end
            if (w_y_hi) begin
                r_y <= gppp_pkg::OUT_MAX;
            end else if (w_y_lo) begin
                r_y <= gppp_pkg::OUT_MIN;
            end else begin
                r_y <= OUT_W'(w_fy);
            end
        end
    end

    gppp_mulsh #(.AW(DIFF_W), .BW(INV_W), .SH(16)) u_mul_h (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_diff),
        .i_b   ($signed({1'b0, w_cfg.inv_n2})),
        .o_p   (w_hfull)
    );

    for (genvar k = 0; k < 3; k++) begin : g_axis
        gppp_mulsh #(.AW(H_W), .BW(COMP_W), .SH(12)) u_mul_t (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_h),
            .i_b   (gppp_pkg::comp(w_cfg.normal, k)),
            .o_p   (w_t[k])
        );

        assign w_d[k] = (D_W'(r_pd[PD_N-1][k]) <<< 16) + D_W'(w_t[k])
                      - (D_W'(gppp_pkg::comp(w_cfg.origin, k)) <<< 12);

        gppp_mulsh #(.AW(D_W), .BW(COMP_W), .SH(12)) u_mul_p (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_d[k]),
            .i_b   (gppp_pkg::comp(w_cfg.p_axis, k)),
            .o_p   (w_sp[k])
        );

        gppp_mulsh #(.AW(D_W), .BW(COMP_W), .SH(12)) u_mul_q (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_d[k]),
            .i_b   (gppp_pkg::comp(w_cfg.q_axis, k)),
            .o_p   (w_sq[k])
        );
    end

    gppp_mulsh #(.AW(S_W), .BW(INV_W), .SH(16)) u_mul_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_sp),
        .i_b   ($signed({1'b0, w_cfg.inv_scales[WORD_W-1:0]})),
        .o_p   (w_fx)
    );

    gppp_mulsh #(.AW(S_W), .BW(INV_W), .SH(16)) u_mul_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_sq),
        .i_b   ($signed({1'b0, w_cfg.inv_scales[2*WORD_W-1:WORD_W]})),
        .o_p   (w_fy)
    );

    assign w_x_hi = w_fx > F_RW'(gppp_pkg::OUT_MAX);
    assign w_x_lo = w_fx < F_RW'(gppp_pkg::OUT_MIN);
    assign w_y_hi = w_fy > F_RW'(gppp_pkg::OUT_MAX);
    assign w_y_lo = w_fy < F_RW'(gppp_pkg::OUT_MIN);

endmodule

>>> src/gppp_mulsh.sv
module gppp_mulsh #(
    parameter int AW = 40,
    parameter int BW = 16,
    parameter int SH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-SH:0] o_p
);

    localparam int LW = 32;
    localparam int HW = AW - LW;
    localparam int PW = AW + BW;
    localparam int QW = PW - SH;
    localparam int RW = QW + 1;

    logic [AW-1:0]    r_am;
    logic [BW-1:0]    r_bm;
    logic             r_neg_a;
    logic [LW+BW-1:0] r_plo;
    logic [HW+BW-1:0] r_phi;
    logic             r_neg_b;
    logic [PW-1:0]    w_sum;
    logic [QW-1:0]    r_q;
    logic             r_neg_c;
    logic [RW-1:0]    w_qx;
    logic signed [RW-1:0] r_p;

    assign w_sum = {r_phi, {LW{1'b0}}} + PW'(r_plo);
    assign w_qx  = {1'b0, r_q};
    assign o_p   = r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am    <= i_a[AW-1] ? -i_a : i_a;
            r_bm    <= i_b[BW-1] ? -i_b : i_b;
            r_neg_a <= i_a[AW-1] ^ i_b[BW-1];
            r_plo   <= r_am[LW-1:0] * r_bm;
            r_phi   <= r_am[AW-1:LW] * r_bm;
            r_neg_b <= r_neg_a;
            r_q     <= w_sum[PW-1:SH];
            r_neg_c <= r_neg_b;
            r_p     <= r_neg_c ? -$signed(w_qx) : $signed(w_qx);
        end
    end

endmodule

>>> src/gppp_cfg.sv
module gppp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gppp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gppp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output gppp_pkg::t_cfg                    o_cfg
);

    gppp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal     <= '0;
            r_cfg.origin     <= '0;
            r_cfg.p_axis     <= '0;
            r_cfg.q_axis     <= '0;
            r_cfg.offset     <= '0;
            r_cfg.inv_n2     <= gppp_pkg::INV_N2_RST;
            r_cfg.inv_scales <= gppp_pkg::INV_SCALES_RST;
            r_cfg.center     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gppp_pkg::REG_NORMAL: r_cfg.normal <= i_cfg_data[gppp_pkg::VEC_W-1:0];
                gppp_pkg::REG_ORIGIN: r_cfg.origin <= i_cfg_data[gppp_pkg::VEC_W-1:0];
                gppp_pkg::REG_P_AXIS: r_cfg.p_axis <= i_cfg_data[gppp_pkg::VEC_W-1:0];
                gppp_pkg::REG_Q_AXIS: r_cfg.q_axis <= i_cfg_data[gppp_pkg::VEC_W-1:0];
                gppp_pkg::REG_OFFSET: r_cfg.offset <= i_cfg_data[gppp_pkg::WORD_W-1:0];
                gppp_pkg::REG_INV_N2: r_cfg.inv_n2 <= i_cfg_data[gppp_pkg::WORD_W-1:0];
                gppp_pkg::REG_INV_SCALES: r_cfg.inv_scales <= i_cfg_data;
                gppp_pkg::REG_CENTER: r_cfg.center <= i_cfg_data[gppp_pkg::WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/gppp_chk.sv
`include "grid_point_plane_projector_macros.svh"

module gppp_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [gppp_pkg::OUT_W-1:0]     o_screen_x,
    input logic signed [gppp_pkg::OUT_W-1:0]     o_screen_y,
    input logic                                  o_saturated
);

    // Hold a stalled result beat.
    `GPPP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_screen_x) && $stable(o_screen_y) && $stable(o_saturated), "stalled result beat changed")

    `GPPP_ASSERT(a_stall_blocks_in, i_clk, i_rst_n, o_valid && !i_ready |-> !o_ready, "point beat taken while result stalled")

    `GPPP_ASSERT(a_sat_clamped, i_clk, i_rst_n, o_valid && o_saturated |-> (o_screen_x == gppp_pkg::OUT_MAX || o_screen_x == gppp_pkg::OUT_MIN || o_screen_y == gppp_pkg::OUT_MAX || o_screen_y == gppp_pkg::OUT_MIN), "saturated flag without clamped coordinate")

    `GPPP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

bind grid_point_plane_projector gppp_chk u_gppp_chk (.*);
